### design/nearest_scaled_center_assign_top_defines.svh
// Assertion macros for the nearest scaled center assignment block.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef NEAREST_SCALED_CENTER_ASSIGN_TOP_DEFINES_SVH
`define NEAREST_SCALED_CENTER_ASSIGN_TOP_DEFINES_SVH

// same-cycle implication
`define NSCA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NSCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/nsca_pkg.sv
// Shared widths and action codes for the nearest scaled center assignment block.
// No dependencies.
package nsca_pkg;
	localparam int MAX_HALOS = 1024;
	localparam int POS_W  = 32;
	localparam int RAD_W  = 31;
	localparam int ID_W   = 32;
	localparam int CNT_W  = 32;
	localparam int HIDX_W = 10;
	localparam int HCNT_W = 11;
	localparam int TBL_W  = 3 * POS_W + RAD_W;
	localparam int DIF_W  = POS_W + 1;
	localparam int SQ_W   = 2 * POS_W + 1;
	localparam int DSQ_W  = 2 * POS_W + 2;
	localparam int R2_W   = 2 * RAD_W;
	localparam int PRD_W  = DSQ_W + R2_W;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;
endpackage

### design/nsca_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module nsca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### design/nearest_scaled_center_assign_top.sv
// A query steps through each entry: for the first, table read, difference, square and sum;
// for each later one the same, then adds products, product sum and compare; then count read
// and write. An empty table is answered without a table read.
// After a query is accepted, no input is taken until its result is issued, output stalls included.
// Reset: a clearing pass over all MAX_HALOS entries zeroes member counts; no item accepted then.
// Depends on nsca_pkg, nsca_ram and nearest_scaled_center_assign_top_defines.svh.
`include "nearest_scaled_center_assign_top_defines.svh"

module nearest_scaled_center_assign_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nsca_pkg::HCNT_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [nsca_pkg::HIDX_W-1:0]   halo_index,
	input  logic signed [nsca_pkg::POS_W-1:0] pos_x,
	input  logic signed [nsca_pkg::POS_W-1:0] pos_y,
	input  logic signed [nsca_pkg::POS_W-1:0] pos_z,
	input  logic [nsca_pkg::RAD_W-1:0]    radius,
	input  logic [nsca_pkg::ID_W-1:0]     particle_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [nsca_pkg::HIDX_W-1:0]   halo_found,
	output logic                          found,
	output logic [nsca_pkg::CNT_W-1:0]    member_count,
	output logic [nsca_pkg::ID_W-1:0]     particle_out
);
	import nsca_pkg::*;

	localparam int AW = (MAX_HALOS > 1) ? $clog2(MAX_HALOS) : 1;
	localparam int CW = $clog2(MAX_HALOS + 1);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_DIF, S_SQ, S_SUM, S_MUL, S_ADD, S_CMP, S_MRD, S_MUPD, S_EMPTY
	} state_t;

	state_t state_q;
	logic [HCNT_W-1:0] hcnt_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] idx_q, n_q;
	logic          first_q;
	logic [POS_W-1:0] px_q, py_q, pz_q;
	logic [ID_W-1:0]  pid_q;
	logic [DIF_W-1:0] dx_q, dy_q, dz_q;
	logic [RAD_W-1:0] r_q;
	logic [SQ_W-1:0]  sx_q, sy_q, sz_q;
	logic [R2_W-1:0]  r2_q;
	logic [DSQ_W-1:0] dsq_q, bd_q;
	logic [R2_W-1:0]  cr2_q, br2_q;
	logic [AW-1:0]    best_q;
	logic [63:0]      lp_q [6];
	logic [63:0]      rp_q [6];
	logic [PRD_W-1:0] lhs_q, rhs_q;
	logic             out_valid_q, found_q;
	logic [HIDX_W-1:0] halo_found_q;
	logic [CNT_W-1:0] cnt_out_q;
	logic [ID_W-1:0]  pid_out_q;

	logic in_acc, ld_we, out_free, last_entry;
	logic [TBL_W-1:0] tbl_wdata, tbl_rdata;
	logic [POS_W-1:0] cx, cy, cz;
	logic [RAD_W-1:0] cr;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [CNT_W-1:0] mem_wdata, mem_rdata, cnt_inc;
	logic [DIF_W-1:0] ddx, ddy, ddz;
	logic [PRD_W-1:0] lsum, rsum;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == S_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign last_entry = (idx_q + CW'(1)) == n_q;
	assign ld_we      = in_acc && (action_t'(action) == ACT_LOAD)
		&& (32'(halo_index) < 32'(MAX_HALOS));
	assign tbl_wdata  = {pos_x, pos_y, pos_z, radius};
	assign {cx, cy, cz, cr} = tbl_rdata;

	nsca_ram #(.WIDTH(TBL_W), .DEPTH(MAX_HALOS)) u_tbl (
		.clk(clk), .we(ld_we), .waddr(AW'(halo_index)), .wdata(tbl_wdata),
		.raddr(idx_q[AW-1:0]), .rdata(tbl_rdata)
	);

	assign cnt_inc   = (mem_rdata == '1) ? mem_rdata : mem_rdata + CNT_W'(1);
	assign mem_we    = (state_q == S_CLR) || (state_q == S_MUPD && out_free);
	assign mem_waddr = (state_q == S_CLR) ? clr_q : best_q;
	assign mem_wdata = (state_q == S_CLR) ? '0 : cnt_inc;

	nsca_ram #(.WIDTH(CNT_W), .DEPTH(MAX_HALOS)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(best_q), .rdata(mem_rdata)
	);

	function automatic logic [DIF_W-1:0] abs_diff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
		logic signed [DIF_W-1:0] d;
		d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
		return d[DIF_W-1] ? DIF_W'(-d) : DIF_W'(d);
	endfunction

	assign ddx = abs_diff(px_q, cx);
	assign ddy = abs_diff(py_q, cy);
	assign ddz = abs_diff(pz_q, cz);

	assign lsum = PRD_W'(lp_q[0]) + (PRD_W'(lp_q[1]) << 32) + (PRD_W'(lp_q[2]) << 32)
		+ (PRD_W'(lp_q[3]) << 64) + (PRD_W'(lp_q[4]) << 64) + (PRD_W'(lp_q[5]) << 96);
	assign rsum = PRD_W'(rp_q[0]) + (PRD_W'(rp_q[1]) << 32) + (PRD_W'(rp_q[2]) << 32)
		+ (PRD_W'(rp_q[3]) << 64) + (PRD_W'(rp_q[4]) << 64) + (PRD_W'(rp_q[5]) << 96);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			hcnt_q      <= '0;
			clr_q       <= '0;
			idx_q       <= '0;
			n_q         <= '0;
			first_q     <= 1'b0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				hcnt_q <= cfg_data;
			end
			if (out_valid_q && out_ready && state_q != S_MUPD && state_q != S_EMPTY) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_HALOS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc && action_t'(action) == ACT_QUERY) begin
						px_q    <= pos_x;
						py_q    <= pos_y;
						pz_q    <= pos_z;
						pid_q   <= particle_id;
						idx_q   <= '0;
						first_q <= 1'b1;
						best_q  <= '0;
						if (32'(hcnt_q) > 32'(MAX_HALOS)) begin
							n_q <= CW'(MAX_HALOS);
						end else begin
							n_q <= CW'(hcnt_q);
						end
						state_q <= (hcnt_q == '0) ? S_EMPTY : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_DIF;
				end
				S_DIF: begin
					dx_q    <= ddx;
					dy_q    <= ddy;
					dz_q    <= ddz;
					r_q     <= cr;
					state_q <= S_SQ;
				end
				S_SQ: begin
					sx_q    <= dx_q * dx_q;
					sy_q    <= dy_q * dy_q;
					sz_q    <= dz_q * dz_q;
					r2_q    <= r_q * r_q;
					state_q <= S_SUM;
				end
				S_SUM: begin
					dsq_q <= DSQ_W'(sx_q) + DSQ_W'(sy_q) + DSQ_W'(sz_q);
					cr2_q <= r2_q;
					if (first_q) begin
						first_q <= 1'b0;
						best_q  <= idx_q[AW-1:0];
						bd_q    <= DSQ_W'(sx_q) + DSQ_W'(sy_q) + DSQ_W'(sz_q);
						br2_q   <= r2_q;
						if (last_entry) begin
							state_q <= S_MRD;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_RD;
						end
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					// candidate distance times best radius squared
					lp_q[0] <= dsq_q[31:0] * br2_q[31:0];
					lp_q[1] <= dsq_q[31:0] * 32'(br2_q[R2_W-1:32]);
					lp_q[2] <= dsq_q[63:32] * br2_q[31:0];
					lp_q[3] <= dsq_q[63:32] * 32'(br2_q[R2_W-1:32]);
					lp_q[4] <= 64'(dsq_q[DSQ_W-1:64]) * 64'(br2_q[31:0]);
					lp_q[5] <= 64'(dsq_q[DSQ_W-1:64]) * 64'(br2_q[R2_W-1:32]);
					// best distance times candidate radius squared
					rp_q[0] <= bd_q[31:0] * cr2_q[31:0];
					rp_q[1] <= bd_q[31:0] * 32'(cr2_q[R2_W-1:32]);
					rp_q[2] <= bd_q[63:32] * cr2_q[31:0];
					rp_q[3] <= bd_q[63:32] * 32'(cr2_q[R2_W-1:32]);
					rp_q[4] <= 64'(bd_q[DSQ_W-1:64]) * 64'(cr2_q[31:0]);
					rp_q[5] <= 64'(bd_q[DSQ_W-1:64]) * 64'(cr2_q[R2_W-1:32]);
					state_q <= S_ADD;
				end
				S_ADD: begin
					lhs_q   <= lsum;
					rhs_q   <= rsum;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (lhs_q < rhs_q) begin
						best_q <= idx_q[AW-1:0];
						bd_q   <= dsq_q;
						br2_q  <= cr2_q;
					end
					if (last_entry) begin
						state_q <= S_MRD;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_RD;
					end
				end
				S_MRD: begin
					state_q <= S_MUPD;
				end
				S_MUPD: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						found_q      <= 1'b1;
						halo_found_q <= HIDX_W'(best_q);
						cnt_out_q    <= cnt_inc;
						pid_out_q    <= pid_q;
						state_q      <= S_IDLE;
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						found_q      <= 1'b0;
						halo_found_q <= '0;
						cnt_out_q    <= '0;
						pid_out_q    <= pid_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign halo_found   = halo_found_q;
	assign member_count = cnt_out_q;
	assign particle_out = pid_out_q;

	`NSCA_ASSERT_NEXT(a_result_after_update, state_q == S_MUPD && out_free, out_valid_q, "no result after count update")
	`NSCA_ASSERT_NEXT(a_busy_after_query, in_acc && action_t'(action) == ACT_QUERY, !in_ready, "query did not block input")
	`NSCA_ASSERT_NOW(a_empty_result, out_valid_q && !found_q, cnt_out_q == '0 && halo_found_q == '0, "empty result not zero")
	`NSCA_ASSERT_NOW(a_no_input_in_clear, state_q == S_CLR, !in_ready, "input taken during clearing pass")
endmodule
